// ===== src/dds_pkg.sv =====
// dds_pkg: shared types, constants and codes of the differential drive steering block
// used by dds_cfg_regs, dds_ctrl, dds_datapath and differential_drive_steering
// no dependencies
package dds_pkg;

  // field and port widths
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned YAW_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned RAMP_W     = 8;

  // shared multiplier
  localparam int unsigned MUL_W  = 18;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // heading ramp
  localparam int unsigned RAMP_STEPS  = 50;
  localparam int unsigned RAMP_START  = 20;
  localparam int unsigned RAMP_MAX    = (1 << RAMP_W) - 1;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RAMP_RECIP  = (1 << RECIP_SHIFT) / RAMP_STEPS;
  localparam int unsigned MAG_W       = 15;

  // position filter, Q8 weights 0.6 new and 0.4 old
  localparam int unsigned FILT_NEW   = 154 * 256;
  localparam int unsigned FILT_OLD   = 102;
  localparam int unsigned FILT_ROUND = 128;
  localparam int unsigned FILT_SHIFT = 8;

  // duty offsets and limits
  localparam int unsigned DUTY_MAX    = 100;
  localparam logic [1:0]  LINE_OFFSET = 2'd2;
  localparam logic [1:0]  HEAD_OFFSET = 2'd1;

  // no line seen
  localparam logic signed [POS_W-1:0] LOST_POS = 8'sh80;

  // mode codes
  localparam logic MODE_LINE    = 1'b0;
  localparam logic MODE_HEADING = 1'b1;

  // register reset values
  localparam logic [6:0]  RST_LINE_SPEED    = 7'd38;
  localparam logic [6:0]  RST_HEADING_SPEED = 7'd46;
  localparam logic [9:0]  RST_LINE_KP       = 10'd77;
  localparam logic [9:0]  RST_LINE_KD       = 10'd307;
  localparam logic [10:0] RST_ANGLE_GAIN    = 11'd640;
  localparam logic [6:0]  RST_STEER_LIMIT   = 7'd40;
  localparam logic [6:0]  RST_TURN_CLAMP    = 7'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_SPEED    = 3'd0,
    REG_HEADING_SPEED = 3'd1,
    REG_LINE_KP       = 3'd2,
    REG_LINE_KD       = 3'd3,
    REG_ANGLE_GAIN    = 3'd4,
    REG_STEER_LIMIT   = 3'd5,
    REG_TURN_CLAMP    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0]  line_speed;
    logic [6:0]  heading_speed;
    logic [9:0]  line_kp;
    logic [9:0]  line_kd;
    logic [10:0] angle_gain;
    logic [6:0]  steer_limit;
    logic [6:0]  turn_clamp;
  } cfg_t;

  // datapath steps, one per controller state
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_MUL1,
    STEP_MUL2,
    STEP_MID,
    STEP_MUL3,
    STEP_MUL4,
    STEP_BASE,
    STEP_OUT
  } step_e;

  typedef struct packed {
    logic  load;
    step_e step;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MID,
    ST_MUL3,
    ST_MUL4,
    ST_BASE,
    ST_OUT
  } ctrl_state_e;

endpackage

// ===== src/differential_drive_steering.sv =====
// differential_drive_steering: top level of the steering block
// depends on dds_pkg, dds_cfg_regs, dds_ctrl and dds_datapath
//
// Each request is one control tick (mode, line position, yaw error, clear flag) and yields
// one pair of wheel duties in 0..100. After acceptance a request walks through seven
// sequencer steps (the last waits for a free output register), four of which use the single
// shared 18 x 18 signed multiplier (filter terms and PD gains in line mode, heading gain,
// ramp product and the ramp division by reciprocal in heading mode). The next request is
// taken once the sequencer is back in idle, even while the last result still waits in the
// output register. Configuration writes take effect at the edge where the write enable is
// high and must only be made while no request is in flight.
module differential_drive_steering (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [dds_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dds_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic signed [dds_pkg::POS_W-1:0]   line_position_i,
  input  logic signed [dds_pkg::YAW_W-1:0]   yaw_error_i,
  input  logic                               clear_last_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dds_pkg::DUTY_W-1:0]         left_duty_o,
  output logic [dds_pkg::DUTY_W-1:0]         right_duty_o
);
  import dds_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // configuration registers
  dds_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer
  dds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic
  dds_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .mode_i          (mode_i),
    .line_position_i (line_position_i),
    .yaw_error_i     (yaw_error_i),
    .clear_last_i    (clear_last_i),
    .left_duty_o     (left_duty_o),
    .right_duty_o    (right_duty_o)
  );

endmodule

// ===== src/dds_cfg_regs.sv =====
// dds_cfg_regs: configuration register file with a plain write port
// depends on dds_pkg
module dds_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output dds_pkg::cfg_t                    cfg_o
);
  import dds_pkg::*;

  cfg_t cfg_q, cfg_d;

  // write decode, unused indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_SPEED:    cfg_d.line_speed    = cfg_wdata_i[6:0];
        REG_HEADING_SPEED: cfg_d.heading_speed = cfg_wdata_i[6:0];
        REG_LINE_KP:       cfg_d.line_kp       = cfg_wdata_i[9:0];
        REG_LINE_KD:       cfg_d.line_kd       = cfg_wdata_i[9:0];
        REG_ANGLE_GAIN:    cfg_d.angle_gain    = cfg_wdata_i[10:0];
        REG_STEER_LIMIT:   cfg_d.steer_limit   = cfg_wdata_i[6:0];
        REG_TURN_CLAMP:    cfg_d.turn_clamp    = cfg_wdata_i[6:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_speed    <= RST_LINE_SPEED;
      cfg_q.heading_speed <= RST_HEADING_SPEED;
      cfg_q.line_kp       <= RST_LINE_KP;
      cfg_q.line_kd       <= RST_LINE_KD;
      cfg_q.angle_gain    <= RST_ANGLE_GAIN;
      cfg_q.steer_limit   <= RST_STEER_LIMIT;
      cfg_q.turn_clamp    <= RST_TURN_CLAMP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/dds_ctrl.sv =====
// dds_ctrl: sequencer that walks one request through the datapath steps
// depends on dds_pkg
module dds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dds_pkg::cmd_t cmd_o
);
  import dds_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_MID;
      ST_MID:  state_d = ST_MUL3;
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = ST_BASE;
      ST_BASE: state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    cmd_o.load  = in_valid_i && (state_q == ST_IDLE);
    cmd_o.step  = STEP_NONE;
    unique case (state_q)
      ST_IDLE: cmd_o.step = STEP_NONE;
      ST_MUL1: cmd_o.step = STEP_MUL1;
      ST_MUL2: cmd_o.step = STEP_MUL2;
      ST_MID:  cmd_o.step = STEP_MID;
      ST_MUL3: cmd_o.step = STEP_MUL3;
      ST_MUL4: cmd_o.step = STEP_MUL4;
      ST_BASE: cmd_o.step = STEP_BASE;
      ST_OUT:  cmd_o.step = out_free ? STEP_OUT : STEP_NONE;
      default: cmd_o.step = STEP_NONE;
    endcase
    if (cmd_o.step == STEP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a request always starts the multiply sequence
  a_load_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_MUL1)
    else $error("request accepted but sequence did not start");

  // a pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step == STEP_OUT |-> !(out_valid_q && !out_ready_i))
    else $error("result written over a pending one");

  // a result only appears out of the write-back state
  a_valid_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result valid raised outside write-back");

  // no request is taken while one is in flight
  a_single_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step != STEP_NONE |-> !cmd_o.load)
    else $error("request accepted while busy");

endmodule

// ===== src/dds_datapath.sv =====
// dds_datapath: filter, PD and P controllers, ramp and duty mixing on one shared multiplier
// depends on dds_pkg
module dds_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dds_pkg::cfg_t                       cfg_i,
  input  dds_pkg::cmd_t                       cmd_i,
  input  logic                                mode_i,
  input  logic signed [dds_pkg::POS_W-1:0]    line_position_i,
  input  logic signed [dds_pkg::YAW_W-1:0]    yaw_error_i,
  input  logic                                clear_last_i,
  output logic [dds_pkg::DUTY_W-1:0]          left_duty_o,
  output logic [dds_pkg::DUTY_W-1:0]          right_duty_o
);
  import dds_pkg::*;

  // request payload
  logic                     mode_q;
  logic signed [POS_W-1:0]  pos_q;
  logic signed [YAW_W-1:0]  yaw_q;
  logic [RAMP_W-1:0]        ramp_use_q;

  // persistent state
  logic signed [15:0]       fpos_q;
  logic signed [15:0]       perr_q;
  logic [RAMP_W-1:0]        ramp_q;
  logic [DUTY_W-1:0]        prev_left_q, prev_right_q;

  // working registers
  logic signed [PROD_W-1:0] prod_q, x1_q, x2_q;
  logic signed [15:0]       err_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     neg_q;
  logic signed [8:0]        base_q;
  logic signed [23:0]       adj_q;
  logic [1:0]               off_q;
  logic [DUTY_W-1:0]        left_q, right_q;

  logic                     lost;
  logic                     standstill;
  logic [RAMP_W-1:0]        ramp_eff;
  logic signed [8:0]        span;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  assign lost = (pos_q == LOST_POS);

  // ramp restart after a standstill
  assign standstill = clear_last_i || (prev_left_q == '0 && prev_right_q == '0);
  assign ramp_eff   = standstill ? '0 : ramp_q;
  assign span       = $signed({2'b00, cfg_i.heading_speed}) - $signed(9'(RAMP_START));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      STEP_MUL1: begin
        if (mode_q == MODE_HEADING) begin
          mul_a = MUL_W'(yaw_q);
          mul_b = $signed(MUL_W'(cfg_i.angle_gain));
        end else begin
          mul_a = MUL_W'(pos_q);
          mul_b = $signed(MUL_W'(FILT_NEW));
        end
      end
      STEP_MUL2: begin
        if (mode_q == MODE_HEADING) begin
          mul_a = $signed(MUL_W'(ramp_use_q));
          mul_b = MUL_W'(span);
        end else begin
          mul_a = MUL_W'(fpos_q);
          mul_b = $signed(MUL_W'(FILT_OLD));
        end
      end
      STEP_MUL3: begin
        if (mode_q == MODE_HEADING) begin
          mul_a = $signed(MUL_W'(mag_q));
          mul_b = $signed(MUL_W'(RAMP_RECIP));
        end else begin
          mul_a = MUL_W'(err_q);
          mul_b = $signed(MUL_W'(cfg_i.line_kp));
        end
      end
      STEP_MUL4: begin
        if (mode_q == MODE_HEADING) begin
          mul_a = $signed(MUL_W'(prod_q[RECIP_SHIFT +: MAG_W]));
          mul_b = $signed(MUL_W'(RAMP_STEPS));
        end else begin
          mul_a = MUL_W'(17'(err_q) - 17'(perr_q));
          mul_b = $signed(MUL_W'(cfg_i.line_kd));
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // filter update and line error
  logic signed [PROD_W-1:0] fsum, fshift;
  logic signed [15:0]       fclamp;
  logic signed [16:0]       fneg;
  logic signed [15:0]       errv;
  logic signed [PROD_W-1:0] pmag;

  always_comb begin
    fsum   = x1_q + prod_q + $signed(PROD_W'(FILT_ROUND));
    fshift = fsum >>> FILT_SHIFT;
    if (fshift > 36'sd32767) begin
      fclamp = 16'sh7fff;
    end else if (fshift < -36'sd32768) begin
      fclamp = 16'sh8000;
    end else begin
      fclamp = fshift[15:0];
    end
    fneg = -17'(fclamp);
    errv = (fneg > 17'sd32767) ? 16'sh7fff : fneg[15:0];
    pmag = prod_q[PROD_W-1] ? -prod_q : prod_q;
  end

  // steering clamp and ramp base
  logic signed [PROD_W-1:0] sel_raw, lim36, clamped;
  logic [MAG_W-1:0]         q0, qv;
  logic signed [PROD_W-1:0] rem;
  logic signed [15:0]       term, b_ramp;
  logic signed [8:0]        base_v;

  always_comb begin
    if (mode_q == MODE_HEADING) begin
      sel_raw = x1_q;
      lim36   = $signed(PROD_W'({cfg_i.turn_clamp, 16'h0000}));
    end else begin
      sel_raw = lost ? '0 : x2_q + prod_q;
      lim36   = $signed(PROD_W'({cfg_i.steer_limit, 16'h0000}));
    end
    if (sel_raw > lim36) begin
      clamped = lim36;
    end else if (sel_raw < -lim36) begin
      clamped = -lim36;
    end else begin
      clamped = sel_raw;
    end
    // quotient by reciprocal, then one correction step
    q0     = x2_q[RECIP_SHIFT +: MAG_W];
    rem    = $signed(PROD_W'(mag_q)) - prod_q;
    qv     = (rem >= $signed(PROD_W'(RAMP_STEPS))) ? q0 + 1'b1 : q0;
    term   = neg_q ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    b_ramp = $signed(16'(RAMP_START)) + term;
    if (mode_q == MODE_HEADING) begin
      base_v = (ramp_use_q < RAMP_W'(RAMP_STEPS)) ? b_ramp[8:0]
                                                   : $signed({2'b00, cfg_i.heading_speed});
    end else begin
      base_v = $signed({2'b00, cfg_i.line_speed});
    end
  end

  // wheel sum, truncated toward zero, offset and saturated
  function automatic logic [DUTY_W-1:0] wheel_duty(input logic signed [8:0]  base,
                                                   input logic signed [24:0] adj,
                                                   input logic [1:0]         off);
    logic signed [26:0] s;
    logic signed [26:0] t;
    logic signed [11:0] d;
    s = 27'($signed({base, 16'h0000})) + 27'(adj);
    t = s[26] ? s + 27'sd65535 : s;
    d = 12'(t >>> 16) + $signed({10'b0, off});
    if (d < 12'sd0) begin
      wheel_duty = '0;
    end else if (d > $signed(12'(DUTY_MAX))) begin
      wheel_duty = DUTY_W'(DUTY_MAX);
    end else begin
      wheel_duty = d[DUTY_W-1:0];
    end
  endfunction

  logic [DUTY_W-1:0] left_v, right_v;

  always_comb begin
    left_v  = wheel_duty(base_q, 25'(adj_q), off_q);
    right_v = wheel_duty(base_q, -25'(adj_q), '0);
  end

  // controller state that persists between requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpos_q       <= '0;
      perr_q       <= '0;
      ramp_q       <= '0;
      prev_left_q  <= '0;
      prev_right_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (clear_last_i) begin
          prev_left_q  <= '0;
          prev_right_q <= '0;
        end
        if (mode_i == MODE_HEADING) begin
          ramp_q <= (ramp_eff == RAMP_W'(RAMP_MAX)) ? ramp_eff : ramp_eff + 1'b1;
        end
      end
      if (cmd_i.step == STEP_MID && mode_q == MODE_LINE && !lost) begin
        fpos_q <= fclamp;
      end
      if (cmd_i.step == STEP_BASE && mode_q == MODE_LINE) begin
        perr_q <= lost ? '0 : err_q;
      end
      if (cmd_i.step == STEP_OUT) begin
        prev_left_q  <= left_v;
        prev_right_q <= right_v;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q     <= mode_i;
      pos_q      <= line_position_i;
      yaw_q      <= yaw_error_i;
      ramp_use_q <= ramp_eff;
    end
    prod_q <= mul_p;
    case (cmd_i.step)
      STEP_MUL2: x1_q <= prod_q;
      STEP_MID: begin
        err_q <= errv;
        mag_q <= pmag[MAG_W-1:0];
        neg_q <= prod_q[PROD_W-1];
      end
      STEP_MUL4: x2_q <= prod_q;
      STEP_BASE: begin
        base_q <= base_v;
        adj_q  <= clamped[23:0];
        off_q  <= (mode_q == MODE_HEADING) ? HEAD_OFFSET : LINE_OFFSET;
      end
      STEP_OUT: begin
        left_q  <= left_v;
        right_q <= right_v;
      end
      default: ;
    endcase
  end

  assign left_duty_o  = left_q;
  assign right_duty_o = right_q;

endmodule

// ===== test/differential_drive_steering_tb.sv =====
// differential_drive_steering_tb: self-checking bench for the steering block, line and heading modes
// depends on dds_pkg and differential_drive_steering from src
`timescale 1ns / 100ps

module differential_drive_steering_tb;
  import dds_pkg::*;

  localparam int  RAMP_FROM   = int'(RAMP_START);
  localparam int  RAMP_LEN    = int'(RAMP_STEPS);
  localparam int  RAMP_CAP    = int'(RAMP_MAX);
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  MAX_REPORTS = 10;

  typedef struct {
    logic                    mode;
    logic signed [POS_W-1:0] pos;
    logic signed [YAW_W-1:0] yaw;
    logic                    clear;
  } tick_t;

  typedef struct {
    logic [DUTY_W-1:0] left;
    logic [DUTY_W-1:0] right;
  } duty_pair_t;

  // ports of the block, all known from time zero
  logic                    clk_i;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i     = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_ready_o;
  logic                    mode_i          = 1'b0;
  logic signed [POS_W-1:0] line_position_i = '0;
  logic signed [YAW_W-1:0] yaw_error_i     = '0;
  logic                    clear_last_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i     = 1'b0;
  logic [DUTY_W-1:0]       left_duty_o;
  logic [DUTY_W-1:0]       right_duty_o;

  // steering model: settings and state
  cfg_t drive_cfg = '{line_speed: RST_LINE_SPEED, heading_speed: RST_HEADING_SPEED,
                      line_kp: RST_LINE_KP, line_kd: RST_LINE_KD,
                      angle_gain: RST_ANGLE_GAIN, steer_limit: RST_STEER_LIMIT,
                      turn_clamp: RST_TURN_CLAMP};
  longint filt_pos   = 0;
  longint prev_err   = 0;
  int     ramp_cnt   = 0;
  int     last_left  = 0;
  int     last_right = 0;

  // request and result bookkeeping
  tick_t      tick_q[$];
  duty_pair_t duty_expect_q[$];
  tick_t      tick_now;
  int         send_gap    = 0;
  int         hold_gap    = 0;
  bit         tx_idle_on  = 1'b1;
  bit         rx_idle_on  = 1'b1;
  int         fail_count  = 0;
  int         results_seen = 0;
  int         cycle_count = 0;

  differential_drive_steering uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .line_position_i (line_position_i),
    .yaw_error_i     (yaw_error_i),
    .clear_last_i    (clear_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_duty_o     (left_duty_o),
    .right_duty_o    (right_duty_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // integer part of a Q16 value, rounded toward zero
  function automatic longint toward_zero_q16(longint x);
    return (x >= 0) ? (x >>> 16) : -((-x) >>> 16);
  endfunction

  // next pair of wheel duties, advancing the filter, ramp and last duties
  function automatic duty_pair_t compute_duties(tick_t t);
    longint     filt_next;
    longint     err;
    longint     steer;
    longint     turn;
    longint     lim;
    longint     ramp_base;
    longint     left;
    longint     right;
    int         span;
    duty_pair_t d;
    if (t.clear) begin
      last_left  = 0;
      last_right = 0;
    end
    if (t.mode == MODE_LINE) begin
      steer = 0;
      if (t.pos == LOST_POS) begin
        // lost line: straight ahead, derivative history dropped
        prev_err = 0;
      end else begin
        filt_next = (longint'(t.pos) * 256 * 154 + filt_pos * 102 + 128) >>> 8;
        filt_next = clip(filt_next, -32768, 32767);
        filt_pos  = filt_next;
        err       = clip(-filt_next, -32768, 32767);
        steer     = err * longint'(drive_cfg.line_kp)
                  + (err - prev_err) * longint'(drive_cfg.line_kd);
        prev_err  = err;
      end
      lim   = longint'(drive_cfg.steer_limit) <<< 16;
      steer = clip(steer, -lim, lim);
      left  = toward_zero_q16((longint'(drive_cfg.line_speed) <<< 16) + steer)
            + longint'(LINE_OFFSET);
      right = toward_zero_q16((longint'(drive_cfg.line_speed) <<< 16) - steer);
    end else begin
      turn = longint'(t.yaw) * longint'(drive_cfg.angle_gain);
      lim  = longint'(drive_cfg.turn_clamp) <<< 16;
      turn = clip(turn, -lim, lim);
      // standing still restarts the speed ramp
      if (last_left == 0 && last_right == 0) ramp_cnt = 0;
      if (ramp_cnt < RAMP_LEN) begin
        span      = int'(drive_cfg.heading_speed) - RAMP_FROM;
        ramp_base = RAMP_FROM + (ramp_cnt * span) / RAMP_LEN;
      end else begin
        ramp_base = longint'(drive_cfg.heading_speed);
      end
      if (ramp_cnt < RAMP_CAP) ramp_cnt++;
      left  = toward_zero_q16((ramp_base <<< 16) + turn) + longint'(HEAD_OFFSET);
      right = toward_zero_q16((ramp_base <<< 16) - turn);
    end
    left       = clip(left, 0, longint'(DUTY_MAX));
    right      = clip(right, 0, longint'(DUTY_MAX));
    last_left  = int'(left);
    last_right = int'(right);
    d.left     = DUTY_W'(left);
    d.right    = DUTY_W'(right);
    return d;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        duty_expect_q.push_back(compute_duties(tick_now));
        send_gap = tx_idle_on ? int'($urandom_range(0, 8)) : 0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tick_now = tick_q.pop_front();
          in_valid_i      <= 1'b1;
          mode_i          <= tick_now.mode;
          line_position_i <= tick_now.pos;
          yaw_error_i     <= tick_now.yaw;
          clear_last_i    <= tick_now.clear;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i) begin
    duty_pair_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (duty_expect_q.size() == 0) begin
          log_failure($sformatf("result %0d (left %0d right %0d) with none expected",
                                results_seen, left_duty_o, right_duty_o));
        end else begin
          want = duty_expect_q.pop_front();
          if (left_duty_o !== want.left || right_duty_o !== want.right)
            log_failure($sformatf("result %0d: expected left %0d right %0d, got left %0d right %0d",
                                  results_seen, want.left, want.right,
                                  left_duty_o, right_duty_o));
        end
        hold_gap = rx_idle_on ? int'($urandom_range(0, 8)) : 0;
      end else if (hold_gap > 0) begin
        hold_gap--;
      end
      out_ready_i <= (hold_gap == 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, duty_expect_q.size());
      $display("[differential_drive_steering] ERROR");
      $finish;
    end
  end

  task automatic push_tick(input logic mode, input int pos, input int yaw, input logic clear);
    tick_t t;
    t.mode  = mode;
    t.pos   = POS_W'(pos);
    t.yaw   = YAW_W'(yaw);
    t.clear = clear;
    tick_q.push_back(t);
  endtask

  // wait until every request has gone in and every result has come back
  task automatic drain_results();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || duty_expect_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_LINE_SPEED:    drive_cfg.line_speed    = value[6:0];
      REG_HEADING_SPEED: drive_cfg.heading_speed = value[6:0];
      REG_LINE_KP:       drive_cfg.line_kp       = value[9:0];
      REG_LINE_KD:       drive_cfg.line_kd       = value[9:0];
      REG_ANGLE_GAIN:    drive_cfg.angle_gain    = value[10:0];
      REG_STEER_LIMIT:   drive_cfg.steer_limit   = value[6:0];
      REG_TURN_CLAMP:    drive_cfg.turn_clamp    = value[6:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [CFG_DATA_W-1:0] line_base, speed_head, kp, kd,
                         angle, steer_lim, turn_lim);
    write_reg(REG_LINE_SPEED, line_base);
    write_reg(REG_HEADING_SPEED, speed_head);
    write_reg(REG_LINE_KP, kp);
    write_reg(REG_LINE_KD, kd);
    write_reg(REG_ANGLE_GAIN, angle);
    write_reg(REG_STEER_LIMIT, steer_lim);
    write_reg(REG_TURN_CLAMP, turn_lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // runs of one mode with a wandering line position and mixed yaw errors
  task automatic queue_random_ticks(input int count);
    int   run_left;
    int   walk;
    int   roll;
    int   pos;
    int   yaw;
    logic run_mode;
    run_left = 0;
    walk     = int'($urandom_range(0, 254)) - 127;
    run_mode = MODE_LINE;
    @(negedge clk_i);
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        run_mode = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 80);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        pos = -128;
      end else if (roll < 16) begin
        pos = int'($urandom_range(0, 255)) - 128;
      end else begin
        walk = int'(clip(walk + int'($urandom_range(0, 20)) - 10, -127, 127));
        pos  = walk;
      end
      roll = $urandom_range(0, 99);
      if (roll < 10)      yaw = int'($urandom_range(0, 131071)) - 65536;
      else if (roll < 15) yaw = roll[0] ? 46080 : -46080;
      else if (roll < 40) yaw = int'($urandom_range(0, 4000)) - 2000;
      else                yaw = int'($urandom_range(0, 92160)) - 46080;
      push_tick(run_mode, pos, yaw, $urandom_range(0, 19) == 0);
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: position extremes, lost line, yaw extremes, standstill, mode switching
    push_tick(MODE_LINE, 0, 0, 1'b0);
    push_tick(MODE_LINE, 127, 0, 1'b0);
    push_tick(MODE_LINE, 127, 0, 1'b0);
    push_tick(MODE_LINE, -127, 0, 1'b0);
    push_tick(MODE_LINE, -128, 0, 1'b0);
    push_tick(MODE_LINE, -1, 0, 1'b0);
    push_tick(MODE_LINE, 1, 0, 1'b1);
    push_tick(MODE_LINE, -128, 65535, 1'b0);
    push_tick(MODE_HEADING, 0, 0, 1'b1);
    push_tick(MODE_HEADING, 127, 46080, 1'b0);
    push_tick(MODE_HEADING, -128, -46080, 1'b0);
    push_tick(MODE_HEADING, 0, 65535, 1'b0);
    push_tick(MODE_HEADING, 0, -65536, 1'b0);
    push_tick(MODE_HEADING, 0, 256, 1'b0);
    push_tick(MODE_HEADING, 0, -1, 1'b0);
    push_tick(MODE_LINE, 64, 0, 1'b0);
    push_tick(MODE_HEADING, 64, 100, 1'b0);
    push_tick(MODE_LINE, -128, 0, 1'b0);
    push_tick(MODE_LINE, -64, 0, 1'b0);
    push_tick(MODE_HEADING, 0, 0, 1'b1);
    drain_results();

    queue_random_ticks(120);
    drain_results();

    // setting phases, each written while the block is idle
    for (int phase = 0; phase < 8; phase++) begin
      tx_idle_on = !(phase == 3 || phase == 5);
      rx_idle_on = !(phase == 3 || phase == 6);
      case (phase)
        0: set_all(100, 100, 1023, 1023, 2047, 100, 100);
        1: set_all(0, 0, 0, 0, 0, 0, 0);
        2: set_all(127, 5, 1023, 0, 2047, 127, 127);
        3: set_all(10, 20, 1023, 1023, 100, 15, 30);
        7: set_all(CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 2047)),
                   CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 2047)),
                   CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 2047)),
                   CFG_DATA_W'($urandom_range(0, 2047)));
        default: set_all(CFG_DATA_W'($urandom_range(0, 100)),
                         CFG_DATA_W'($urandom_range(20, 100)),
                         CFG_DATA_W'($urandom_range(0, 1023)),
                         CFG_DATA_W'($urandom_range(0, 1023)),
                         CFG_DATA_W'($urandom_range(0, 2047)),
                         CFG_DATA_W'($urandom_range(0, 100)),
                         CFG_DATA_W'($urandom_range(0, 100)));
      endcase
      queue_random_ticks(120);
      drain_results();
    end

    // settle, then verdict
    repeat (16) @(posedge clk_i);
    if (duty_expect_q.size() != 0)
      log_failure($sformatf("%0d results never arrived", duty_expect_q.size()));
    if (fail_count == 0) begin
      $display("[differential_drive_steering] OK");
    end else begin
      $display("[differential_drive_steering] ERROR");
    end
    $finish;
  end

endmodule
